FILE: src/subtitle_packet_rle_decoder_defines.svh
// assertion macros for the subtitle packet decoder checker
// no dependencies; taken in by the checker file
`ifndef SUBTITLE_PACKET_RLE_DECODER_DEFINES_SVH
`define SUBTITLE_PACKET_RLE_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SPRD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sprd check failed");

// next-cycle implication, disabled during reset
`define SPRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sprd check failed");

`endif

FILE: src/sprd_pkg.sv
// shared types, constants and header table for the subtitle packet decoder
// no dependencies
package sprd_pkg;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       packet_start;
      logic       packet_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  item_kind;
      logic [3:0]  field_index;
      logic [31:0] item_value;
      logic [8:0]  run_length;
      logic        final_item;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } res_type;

   localparam logic [1:0] KIND_FIELD    = 2'd0;
   localparam logic [1:0] KIND_RUN      = 2'd1;
   localparam logic [1:0] KIND_SYNC_ERR = 2'd2;
   localparam logic [1:0] KIND_TRUNC    = 2'd3;

   localparam logic [7:0] SYNC_BYTE    = 8'hCC;
   localparam logic [4:0] SYNC_LAST    = 5'd15;
   localparam logic [4:0] SYNC_CHECKED = 5'd4;
   localparam logic [4:0] RUN_SECTION  = 5'd6;
   localparam logic [4:0] LIT_SECTION  = 5'd4;
   localparam logic [3:0] LAST_FIELD   = 4'd13;

   // header byte offset to (field index + 1), zero where no field ends
   function automatic logic [3:0] field_end(input logic [4:0] pos);
      logic [3:0] fe;
      case (pos)
         5'd1:    fe = 4'd1;
         5'd3:    fe = 4'd2;
         5'd5:    fe = 4'd3;
         5'd7:    fe = 4'd4;
         5'd9:    fe = 4'd5;
         5'd12:   fe = 4'd6;
         5'd15:   fe = 4'd7;
         5'd16:   fe = 4'd8;
         5'd17:   fe = 4'd9;
         5'd18:   fe = 4'd10;
         5'd19:   fe = 4'd11;
         5'd23:   fe = 4'd12;
         5'd27:   fe = 4'd13;
         5'd31:   fe = 4'd14;
         default: fe = 4'd0;
      endcase
      return fe;
   endfunction

endpackage

FILE: src/sprd_skid.sv
// two-entry result stage: output register plus skid register
// depends on sprd_pkg
module sprd_skid
   import sprd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  res_type res_in,
   output logic    res_ready,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_ready
);

   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;

   assign res_ready = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= res_in.valid;
            out_data_ff  <= res_in.data;
         end
      end else if (res_in.valid && !skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= res_in.data;
      end
   end

endmodule

FILE: src/sprd_parser.sv
// byte parser: sync check, header field unpacking and section decoding
// depends on sprd_pkg
module sprd_parser
   import sprd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output res_type res
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_SYNC, PH_HEADER, PH_MARKER, PH_DATA, PH_LIT, PH_RUN, PH_DONE
   } phase_type;

   phase_type   phase_ff,  phase_in;
   logic [4:0]  pos_ff,    pos_in;
   logic [31:0] acc_ff,    acc_in;
   logic [7:0]  marker_ff, marker_in;
   logic [31:0] remain_ff, remain_in;
   logic [8:0]  count_ff,  count_in;
   logic        failed_ff, failed_in;

   always_comb begin
      phase_type   cur_phase;
      logic [4:0]  cur_pos;
      logic [31:0] cur_acc;
      logic [7:0]  cur_marker;
      logic [31:0] cur_remain;
      logic [8:0]  cur_count;
      logic        cur_failed;
      logic [3:0]  fe;
      logic [31:0] acc_shift;
      logic [4:0]  pos_next;
      logic        last_byte;
      logic        is_run;
      logic        fin;

      if (req.packet_start) begin
         cur_phase  = PH_SYNC;
         cur_pos    = '0;
         cur_acc    = '0;
         cur_marker = '0;
         cur_remain = '0;
         cur_count  = '0;
         cur_failed = 1'b0;
      end else begin
         cur_phase  = phase_ff;
         cur_pos    = pos_ff;
         cur_acc    = acc_ff;
         cur_marker = marker_ff;
         cur_remain = remain_ff;
         cur_count  = count_ff;
         cur_failed = failed_ff;
      end

      phase_in  = cur_phase;
      pos_in    = cur_pos;
      acc_in    = cur_acc;
      marker_in = cur_marker;
      remain_in = cur_remain;
      count_in  = cur_count;
      failed_in = cur_failed;
      res       = '0;

      fe        = field_end(cur_pos);
      acc_shift = {cur_acc[23:0], req.byte_value};
      pos_next  = cur_pos + 5'd1;
      last_byte = (cur_remain == 32'd1);
      is_run    = (cur_phase == PH_RUN);
      fin       = 1'b0;

      case (cur_phase)
         PH_SYNC: begin
            failed_in = cur_failed ||
                        ((cur_pos < SYNC_CHECKED) && (req.byte_value != SYNC_BYTE));
            if ((cur_pos == SYNC_CHECKED - 5'd1) && failed_in) begin
               res.valid           = 1'b1;
               res.data.item_kind  = KIND_SYNC_ERR;
               res.data.final_item = 1'b1;
               phase_in            = PH_DONE;
            end else if (cur_pos == SYNC_LAST) begin
               phase_in = PH_HEADER;
               pos_in   = '0;
               acc_in   = '0;
            end else begin
               pos_in = pos_next;
            end
         end
         PH_HEADER: begin
            pos_in = pos_next;
            acc_in = acc_shift;
            if (fe != 4'd0) begin
               if (fe - 4'd1 == LAST_FIELD) begin
                  remain_in = acc_shift;
                  fin       = (acc_shift <= 32'd1);
                  phase_in  = (acc_shift == 32'd0) ? PH_DONE : PH_MARKER;
               end
               res.valid            = 1'b1;
               res.data.item_kind   = KIND_FIELD;
               res.data.field_index = fe - 4'd1;
               res.data.item_value  = acc_shift;
               res.data.final_item  = fin;
               acc_in               = '0;
            end
         end
         PH_MARKER: begin
            marker_in = req.byte_value;
            remain_in = cur_remain - 32'd1;
            phase_in  = last_byte ? PH_DONE : PH_DATA;
         end
         PH_DATA: begin
            remain_in = cur_remain - 32'd1;
            pos_in    = 5'd1;
            if (req.byte_value == cur_marker) begin
               phase_in = PH_RUN;
               acc_in   = '0;
            end else begin
               phase_in = PH_LIT;
               acc_in   = {24'd0, req.byte_value};
            end
            if (last_byte) begin
               res.valid           = 1'b1;
               res.data.item_kind  = KIND_TRUNC;
               res.data.final_item = 1'b1;
               phase_in            = PH_DONE;
            end
         end
         PH_LIT, PH_RUN: begin
            remain_in = cur_remain - 32'd1;
            if (is_run && (cur_pos == 5'd1)) begin
               count_in = {1'b0, req.byte_value} + 9'd1;
            end else begin
               acc_in = acc_shift;
            end
            pos_in = pos_next;
            if (pos_next >= (is_run ? RUN_SECTION : LIT_SECTION)) begin
               res.valid           = 1'b1;
               res.data.item_kind  = KIND_RUN;
               res.data.item_value = acc_in;
               res.data.run_length = is_run ? count_in : 9'd1;
               res.data.final_item = last_byte;
               pos_in              = '0;
               acc_in              = '0;
               phase_in            = last_byte ? PH_DONE : PH_DATA;
            end else if (last_byte) begin
               res.valid           = 1'b1;
               res.data.item_kind  = KIND_TRUNC;
               res.data.final_item = 1'b1;
               phase_in            = PH_DONE;
            end
         end
         default: begin
         end
      endcase

      // early end of packet overrides any other result
      if (req.packet_end && (phase_in != PH_DONE) && (phase_in != PH_IDLE)) begin
         res                 = '0;
         res.valid           = 1'b1;
         res.data.item_kind  = KIND_TRUNC;
         res.data.final_item = 1'b1;
         phase_in            = PH_DONE;
      end

      res.valid = res.valid && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         failed_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         failed_ff <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         acc_ff    <= acc_in;
         marker_ff <= marker_in;
         remain_ff <= remain_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: src/subtitle_packet_rle_decoder.sv
// top level of the subtitle packet run-length decoder
// depends on sprd_pkg, sprd_parser and sprd_skid
//
// Takes one packet byte per transfer and can take a new byte every cycle while
// req_ready is high. Each byte updates the parser state in the cycle it is
// taken. Results pass through a two-entry output stage, the output register
// and the skid register, so bytes keep flowing while one result waits;
// req_ready falls only when both entries are full and recovers the cycle
// after the downstream side takes a result. No start-up sweep after reset.
module subtitle_packet_rle_decoder
   import sprd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   res_type res;
   logic    accept;

   assign accept = req_valid && req_ready;

   sprd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .res    (res)
   );

   sprd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .res_in    (res),
      .res_ready (req_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload),
      .out_ready (rsp_ready)
   );

endmodule

FILE: src/sprd_checker.sv
// port-level checker for the subtitle packet decoder, bound to the top level
// depends on sprd_pkg and subtitle_packet_rle_decoder_defines.svh
`include "subtitle_packet_rle_decoder_defines.svh"

module sprd_port_checker
   import sprd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   logic req_xfer;
   logic rsp_stall;
   logic rsp_error;
   logic rsp_run;
   logic rsp_field;
   logic error_ok;
   logic run_ok;
   logic field_ok;

   assign req_xfer  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_error = rsp_valid && (rsp_payload.item_kind inside {KIND_SYNC_ERR, KIND_TRUNC});
   assign rsp_run   = rsp_valid && (rsp_payload.item_kind == KIND_RUN);
   assign rsp_field = rsp_valid && (rsp_payload.item_kind == KIND_FIELD);
   assign error_ok  = rsp_payload.final_item && (rsp_payload.item_value == 32'd0);
   assign run_ok    = (rsp_payload.run_length != 9'd0) && (rsp_payload.field_index == 4'd0);
   assign field_ok  = (rsp_payload.run_length == 9'd0) && (rsp_payload.field_index <= LAST_FIELD);

   `SPRD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))
   `SPRD_ASSERT_NOW(a_error_final, clock, reset, rsp_error, error_ok)
   `SPRD_ASSERT_NOW(a_run_length, clock, reset, rsp_run, run_ok)
   `SPRD_ASSERT_NOW(a_field_shape, clock, reset, rsp_field, field_ok)
   `SPRD_ASSERT_NEXT(a_no_invented, clock, reset, !rsp_valid && !req_xfer, !rsp_valid)

endmodule

bind subtitle_packet_rle_decoder sprd_port_checker u_checker (.*);
